[hdl/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for pressure/temperature compensation.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

    typedef struct packed {
        logic [19:0] adc_pressure;
        logic [19:0] adc_temperature;
    } t_ptc_in;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               pressure_invalid;
    } t_ptc_out;

    localparam logic [1:0] CFG_TEMP_CALIB    = 2'd0;
    localparam logic [1:0] CFG_PRESS_CALIB_A = 2'd1;
    localparam logic [1:0] CFG_PRESS_CALIB_B = 2'd2;
    localparam logic [1:0] CFG_PRESS_CALIB_C = 2'd3;

    localparam logic signed [14:0] TEMP_MIN_CENTI = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX_CENTI = 15'sd8500;
    localparam logic signed [24:0] T_FINE_OFFSET  = 25'sd128000;
    localparam logic [20:0]        ADC_FULL_SCALE = 21'd1048576;
    localparam logic [11:0]        PRESS_SCALE    = 12'd3125;
    localparam logic [63:0]        V1_BIAS        = 64'h0000_8000_0000_0000;

    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 31;
    localparam int DIV_TAG_W = 17;

endpackage

`default_nettype wire

[hdl/pressure_temp_compensation.sv]
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Pipeline: the pre-divider stages, the ptc_div stages, the post-divider
//   stages and the output register; the divider stages make up most of it.
// Throughput: one item per cycle while not stalled; every stage is registered
//   and advances together, empty stages fill while a finished result waits.
// Reset: synchronous, active low; clears all valid bits and the calibration
//   registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temp_compensation
    import ptc_pkg::*;
#(
    parameter int DIV_BITS = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire t_ptc_in     i_in_item,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_ptc_out         o_out_item,
    input  wire logic        i_out_stall,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);

    // calibration registers
    logic [47:0] r_temp_calib;
    logic [63:0] r_press_calib_a;
    logic [63:0] r_press_calib_b;
    logic [15:0] r_press_calib_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib    <= '0;
            r_press_calib_a <= '0;
            r_press_calib_b <= '0;
            r_press_calib_c <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEMP_CALIB:    r_temp_calib    <= i_cfg_data[47:0];
                CFG_PRESS_CALIB_A: r_press_calib_a <= i_cfg_data;
                CFG_PRESS_CALIB_B: r_press_calib_b <= i_cfg_data;
                CFG_PRESS_CALIB_C: r_press_calib_c <= i_cfg_data[15:0];
            endcase
        end
    end

    logic [15:0]        c_t1, c_p1;
    logic signed [15:0] c_t2, c_t3, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9;

    assign c_t1 = r_temp_calib[15:0];
    assign c_t2 = r_temp_calib[31:16];
    assign c_t3 = r_temp_calib[47:32];
    assign c_p1 = r_press_calib_a[15:0];
    assign c_p2 = r_press_calib_a[31:16];
    assign c_p3 = r_press_calib_a[47:32];
    assign c_p4 = r_press_calib_a[63:48];
    assign c_p5 = r_press_calib_b[15:0];
    assign c_p6 = r_press_calib_b[31:16];
    assign c_p7 = r_press_calib_b[47:32];
    assign c_p8 = r_press_calib_b[63:48];
    assign c_p9 = r_press_calib_c;

    // pipeline control
    logic       w_en;
    logic       w_out_ld;
    logic       r_out_v;
    logic       r_se_v;
    logic [11:0] r_v;
    logic [4:0]  r_pv;

    assign w_out_ld   = !r_out_v || !i_out_stall;
    assign w_en       = !r_se_v || w_out_ld;
    assign o_in_stall = !w_en;

    // stage registers
    logic signed [17:0] r_s1_d1;
    logic signed [16:0] r_s1_d2;
    logic [20:0]        r_s1_padc;
    logic signed [33:0] r_s2_m1;
    logic [31:0]        r_s2_sq;
    logic [20:0]        r_s2_padc;
    logic signed [22:0] r_s3_v1t;
    logic signed [36:0] r_s3_m3;
    logic [20:0]        r_s3_padc;
    logic signed [23:0] r_s4_tf;
    logic [20:0]        r_s4_padc;
    logic signed [14:0] r_s5_tc;
    logic signed [24:0] r_s5_pv1;
    logic [20:0]        r_s5_padc;
    logic [47:0]        r_s6_sq;
    logic signed [40:0] r_s6_m5, r_s6_m2;
    logic signed [14:0] r_s6_tc;
    logic [20:0]        r_s6_padc;
    logic signed [40:0] r_s7_h6, r_s7_l6, r_s7_h3, r_s7_l3, r_s7_m5, r_s7_m2;
    logic signed [14:0] r_s7_tc;
    logic [20:0]        r_s7_padc;
    logic signed [63:0] r_s8_v2, r_s8_v1;
    logic signed [14:0] r_s8_tc;
    logic [20:0]        r_s8_padc;
    logic [63:0]        r_s9_a, r_s9_x;
    logic signed [14:0] r_s9_tc;
    logic [47:0]        r_s10_al;
    logic [31:0]        r_s10_ah;
    logic [43:0]        r_s10_xl;
    logic [31:0]        r_s10_xh;
    logic signed [14:0] r_s10_tc;
    logic signed [30:0] r_s11_d;
    logic [63:0]        r_s11_n;
    logic signed [14:0] r_s11_tc;
    logic [63:0]        r_s12_magn;
    logic [30:0]        r_s12_magd;
    logic [DIV_TAG_W-1:0] r_s12_tag;

    logic [63:0]        r_sq_p;
    logic signed [14:0] r_sq_tc;
    logic               r_sq_inv;
    logic [63:0]        r_sa_a, r_sa_p;
    logic signed [48:0] r_sa_al, r_sa_bl;
    logic [31:0]        r_sa_ah, r_sa_bh;
    logic signed [14:0] r_sa_tc;
    logic               r_sa_inv;
    logic [63:0]        r_sb_b, r_sb_a, r_sb_p;
    logic signed [63:0] r_sb_v2;
    logic signed [14:0] r_sb_tc;
    logic               r_sb_inv;
    logic [63:0]        r_sc_ll, r_sc_p;
    logic [31:0]        r_sc_lh, r_sc_hl;
    logic signed [63:0] r_sc_v2;
    logic signed [14:0] r_sc_tc;
    logic               r_sc_inv;
    logic signed [63:0] r_sd_v1, r_sd_v2;
    logic [63:0]        r_sd_p;
    logic signed [14:0] r_sd_tc;
    logic               r_sd_inv;
    t_ptc_out           r_se_item;
    t_ptc_out           r_out_item;

    // next values
    logic signed [17:0] n_s1_d1;
    logic signed [16:0] n_s1_d2;
    logic [20:0]        n_s1_padc;
    logic signed [33:0] n_s2_m1;
    logic [31:0]        n_s2_sq;
    logic signed [36:0] n_s3_m3;
    logic signed [23:0] n_s4_tf;
    logic signed [14:0] n_s5_tc;
    logic signed [24:0] n_s5_pv1;
    logic [47:0]        n_s6_sq;
    logic signed [40:0] n_s6_m5, n_s6_m2;
    logic signed [40:0] n_s7_h6, n_s7_l6, n_s7_h3, n_s7_l3;
    logic signed [63:0] n_s8_v2, n_s8_v1;
    logic [63:0]        n_s9_a, n_s9_x;
    logic [47:0]        n_s10_al;
    logic [31:0]        n_s10_ah;
    logic [43:0]        n_s10_xl;
    logic [31:0]        n_s10_xh;
    logic signed [30:0] n_s11_d;
    logic [63:0]        n_s11_n;
    logic [63:0]        n_s12_magn;
    logic [30:0]        n_s12_magd;
    logic [DIV_TAG_W-1:0] n_s12_tag;
    logic [63:0]        n_sq_p;
    logic [63:0]        n_sa_a;
    logic signed [48:0] n_sa_al, n_sa_bl;
    logic [31:0]        n_sa_ah, n_sa_bh;
    logic [63:0]        n_sb_b;
    logic signed [63:0] n_sb_v2;
    logic [63:0]        n_sc_ll;
    logic [31:0]        n_sc_lh, n_sc_hl;
    logic signed [63:0] n_sd_v1;
    t_ptc_out           n_se_item;

    // divider ports
    logic                 w_div_v;
    logic [63:0]          w_div_q;
    logic [DIV_TAG_W-1:0] w_div_tag;

    always_comb begin
        logic signed [33:0] sq34;
        logic signed [26:0] tf5;
        logic signed [18:0] tcw;
        logic signed [49:0] sq50;
        logic signed [63:0] h6, l6, h3, l3, m5, m2, p4;
        logic [63:0]        proda;
        logic signed [63:0] al64, bl64, pb, cc;
        logic [39:0]        s40;
        logic [31:0]        press;

        // temperature path
        n_s1_d1   = $signed({1'b0, i_in_item.adc_temperature[19:3]})
                  - $signed({1'b0, c_t1, 1'b0});
        n_s1_d2   = $signed({1'b0, i_in_item.adc_temperature[19:4]})
                  - $signed({1'b0, c_t1});
        n_s1_padc = ADC_FULL_SCALE - {1'b0, i_in_item.adc_pressure};

        n_s2_m1 = r_s1_d1 * c_t2;
        sq34    = r_s1_d2 * r_s1_d2;
        n_s2_sq = sq34[31:0];

        n_s3_m3 = $signed({1'b0, r_s2_sq[31:12]}) * c_t3;

        n_s4_tf = {r_s3_v1t[22], r_s3_v1t} + {r_s3_m3[36], r_s3_m3[36:14]};

        tf5 = r_s4_tf * 27'sd5 + 27'sd128;
        tcw = tf5[26:8];
        if (tcw < TEMP_MIN_CENTI) begin
            n_s5_tc = TEMP_MIN_CENTI;
        end else if (tcw > TEMP_MAX_CENTI) begin
            n_s5_tc = TEMP_MAX_CENTI;
        end else begin
            n_s5_tc = tcw[14:0];
        end
        n_s5_pv1 = r_s4_tf - T_FINE_OFFSET;

        // pressure path
        sq50    = r_s5_pv1 * r_s5_pv1;
        n_s6_sq = sq50[47:0];
        n_s6_m5 = r_s5_pv1 * c_p5;
        n_s6_m2 = r_s5_pv1 * c_p2;

        n_s7_h6 = $signed({1'b0, r_s6_sq[47:24]}) * c_p6;
        n_s7_l6 = $signed({1'b0, r_s6_sq[23:0]}) * c_p6;
        n_s7_h3 = $signed({1'b0, r_s6_sq[47:24]}) * c_p3;
        n_s7_l3 = $signed({1'b0, r_s6_sq[23:0]}) * c_p3;

        h6 = r_s7_h6;
        l6 = r_s7_l6;
        h3 = r_s7_h3;
        l3 = r_s7_l3;
        m5 = r_s7_m5;
        m2 = r_s7_m2;
        p4 = c_p4;
        n_s8_v2 = (h6 <<< 24) + l6 + (m5 <<< 17) + (p4 <<< 35);
        n_s8_v1 = (((h3 <<< 24) + l3) >>> 8) + (m2 <<< 12);

        n_s9_a = r_s8_v1 + V1_BIAS;
        n_s9_x = ({43'd0, r_s8_padc} << 31) - r_s8_v2;

        n_s10_al = r_s9_a[31:0] * c_p1;
        n_s10_ah = r_s9_a[63:32] * c_p1;
        n_s10_xl = r_s9_x[31:0] * PRESS_SCALE;
        n_s10_xh = r_s9_x[63:32] * PRESS_SCALE;

        proda   = {16'd0, r_s10_al} + {r_s10_ah, 32'd0};
        n_s11_d = proda[63:33];
        n_s11_n = {20'd0, r_s10_xl} + {r_s10_xh, 32'd0};

        n_s12_magn = r_s11_n[63] ? (64'd0 - r_s11_n) : r_s11_n;
        n_s12_magd = r_s11_d[30] ? (31'd0 - r_s11_d) : r_s11_d;
        n_s12_tag  = {r_s11_tc, (r_s11_d == 31'sd0), r_s11_n[63] ^ r_s11_d[30]};

        // after the divider
        n_sq_p = w_div_tag[0] ? (64'd0 - w_div_q) : w_div_q;

        n_sa_a  = {{13{r_sq_p[63]}}, r_sq_p[63:13]};
        n_sa_al = $signed({1'b0, n_sa_a[31:0]}) * c_p9;
        n_sa_ah = $signed(n_sa_a[63:32]) * c_p9;
        n_sa_bl = $signed({1'b0, r_sq_p[31:0]}) * c_p8;
        n_sa_bh = $signed(r_sq_p[63:32]) * c_p8;

        al64    = r_sa_al;
        bl64    = r_sa_bl;
        n_sb_b  = al64 + {r_sa_ah, 32'd0};
        pb      = bl64 + {r_sa_bh, 32'd0};
        n_sb_v2 = pb >>> 19;

        n_sc_ll = r_sb_b[31:0] * r_sb_a[31:0];
        n_sc_lh = r_sb_b[31:0] * r_sb_a[63:32];
        n_sc_hl = r_sb_b[63:32] * r_sb_a[31:0];

        cc      = r_sc_ll + {r_sc_lh + r_sc_hl, 32'd0};
        n_sd_v1 = cc >>> 25;

        s40   = r_sd_p[39:0] + r_sd_v1[39:0] + r_sd_v2[39:0];
        press = s40[39:8] + {{12{c_p7[15]}}, c_p7, 4'd0};
        n_se_item.temperature_centi = r_sd_tc;
        n_se_item.pressure_q24_8    = r_sd_inv ? 32'd0 : press;
        n_se_item.pressure_invalid  = r_sd_inv;
    end

    ptc_div #(
        .BITS  (DIV_BITS),
        .TAG_W (DIV_TAG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_v[11]),
        .i_dividend (r_s12_magn),
        .i_divisor  (r_s12_magd),
        .i_tag      (r_s12_tag),
        .o_valid    (w_div_v),
        .o_quotient (w_div_q),
        .o_tag      (w_div_tag)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_pv    <= '0;
            r_se_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_v    <= {r_v[10:0], i_in_valid};
                r_pv   <= {r_pv[3:0], w_div_v};
                r_se_v <= r_pv[4];
            end
            if (w_out_ld) begin
                r_out_v <= r_se_v;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_d1   <= n_s1_d1;
            r_s1_d2   <= n_s1_d2;
            r_s1_padc <= n_s1_padc;
            r_s2_m1   <= n_s2_m1;
            r_s2_sq   <= n_s2_sq;
            r_s2_padc <= r_s1_padc;
            r_s3_v1t  <= r_s2_m1[33:11];
            r_s3_m3   <= n_s3_m3;
            r_s3_padc <= r_s2_padc;
            r_s4_tf   <= n_s4_tf;
            r_s4_padc <= r_s3_padc;
            r_s5_tc   <= n_s5_tc;
            r_s5_pv1  <= n_s5_pv1;
            r_s5_padc <= r_s4_padc;
            r_s6_sq   <= n_s6_sq;
            r_s6_m5   <= n_s6_m5;
            r_s6_m2   <= n_s6_m2;
            r_s6_tc   <= r_s5_tc;
            r_s6_padc <= r_s5_padc;
            r_s7_h6   <= n_s7_h6;
            r_s7_l6   <= n_s7_l6;
            r_s7_h3   <= n_s7_h3;
            r_s7_l3   <= n_s7_l3;
            r_s7_m5   <= r_s6_m5;
            r_s7_m2   <= r_s6_m2;
            r_s7_tc   <= r_s6_tc;
            r_s7_padc <= r_s6_padc;
            r_s8_v2   <= n_s8_v2;
            r_s8_v1   <= n_s8_v1;
            r_s8_tc   <= r_s7_tc;
            r_s8_padc <= r_s7_padc;
            r_s9_a    <= n_s9_a;
            r_s9_x    <= n_s9_x;
            r_s9_tc   <= r_s8_tc;
            r_s10_al  <= n_s10_al;
            r_s10_ah  <= n_s10_ah;
            r_s10_xl  <= n_s10_xl;
            r_s10_xh  <= n_s10_xh;
            r_s10_tc  <= r_s9_tc;
            r_s11_d   <= n_s11_d;
            r_s11_n   <= n_s11_n;
            r_s11_tc  <= r_s10_tc;
            r_s12_magn <= n_s12_magn;
            r_s12_magd <= n_s12_magd;
            r_s12_tag  <= n_s12_tag;

            r_sq_p   <= n_sq_p;
            r_sq_tc  <= w_div_tag[DIV_TAG_W-1:2];
            r_sq_inv <= w_div_tag[1];
            r_sa_a   <= n_sa_a;
            r_sa_p   <= r_sq_p;
            r_sa_al  <= n_sa_al;
            r_sa_ah  <= n_sa_ah;
            r_sa_bl  <= n_sa_bl;
            r_sa_bh  <= n_sa_bh;
            r_sa_tc  <= r_sq_tc;
            r_sa_inv <= r_sq_inv;
            r_sb_b   <= n_sb_b;
            r_sb_a   <= r_sa_a;
            r_sb_p   <= r_sa_p;
            r_sb_v2  <= n_sb_v2;
            r_sb_tc  <= r_sa_tc;
            r_sb_inv <= r_sa_inv;
            r_sc_ll  <= n_sc_ll;
            r_sc_lh  <= n_sc_lh;
            r_sc_hl  <= n_sc_hl;
            r_sc_p   <= r_sb_p;
            r_sc_v2  <= r_sb_v2;
            r_sc_tc  <= r_sb_tc;
            r_sc_inv <= r_sb_inv;
            r_sd_v1  <= n_sd_v1;
            r_sd_v2  <= r_sc_v2;
            r_sd_p   <= r_sc_p;
            r_sd_tc  <= r_sc_tc;
            r_sd_inv <= r_sc_inv;
            r_se_item <= n_se_item;
        end
        if (w_out_ld) begin
            r_out_item <= r_se_item;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

[hdl/ptc_div.sv]
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined restoring divider: unsigned 64-bit dividend by 31-bit divisor,
// BITS quotient bits per stage, with a sideband tag carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_div
    import ptc_pkg::*;
#(
    parameter int BITS  = 2,
    parameter int TAG_W = 17
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [DIV_N_W-1:0] i_dividend,
    input  wire logic [DIV_D_W-1:0] i_divisor,
    input  wire logic [TAG_W-1:0]   i_tag,
    output logic                    o_valid,
    output logic [DIV_N_W-1:0]      o_quotient,
    output logic [TAG_W-1:0]        o_tag
);

    localparam int NSTG = DIV_N_W / BITS;

    logic [DIV_D_W-1:0] r_rem  [NSTG];
    logic [DIV_N_W-1:0] r_work [NSTG];
    logic [DIV_D_W-1:0] r_dv   [NSTG];
    logic [TAG_W-1:0]   r_tag  [NSTG];
    logic [NSTG-1:0]    r_v;

    for (genvar g = 0; g < NSTG; g++) begin : g_stg
        logic [DIV_D_W-1:0] rem_in;
        logic [DIV_N_W-1:0] work_in;
        logic [DIV_D_W-1:0] dv_in;
        logic [TAG_W-1:0]   tag_in;
        logic               v_in;
        logic [DIV_D_W-1:0] n_rem;
        logic [DIV_N_W-1:0] n_work;

        if (g == 0) begin : g_first
            assign rem_in  = '0;
            assign work_in = i_dividend;
            assign dv_in   = i_divisor;
            assign tag_in  = i_tag;
            assign v_in    = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign work_in = r_work[g-1];
            assign dv_in   = r_dv[g-1];
            assign tag_in  = r_tag[g-1];
            assign v_in    = r_v[g-1];
        end

        always_comb begin
            logic [DIV_D_W:0] t;
            logic             ge;
            n_rem  = rem_in;
            n_work = work_in;
            for (int j = 0; j < BITS; j++) begin
                t      = {n_rem, n_work[DIV_N_W-1]};
                ge     = (t >= {1'b0, dv_in});
                n_work = {n_work[DIV_N_W-2:0], ge};
                if (ge) begin
                    n_rem = DIV_D_W'(t - {1'b0, dv_in});
                end else begin
                    n_rem = t[DIV_D_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_work[g] <= n_work;
                r_dv[g]   <= dv_in;
                r_tag[g]  <= tag_in;
            end
        end
    end

    assign o_valid    = r_v[NSTG-1];
    assign o_quotient = r_work[NSTG-1];
    assign o_tag      = r_tag[NSTG-1];

endmodule

`default_nettype wire

[hdl/ptc_chk.sv]
// ----------------------------------------------------------------------------
// ptc_chk
// Port-level checks for pressure_temp_compensation, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_chk
    import ptc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire t_ptc_out    o_out_item,
    input wire logic        i_out_stall
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("item dropped while stalled");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled item changed");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.temperature_centi >= TEMP_MIN_CENTI)
                     && (o_out_item.temperature_centi <= TEMP_MAX_CENTI))
        else $error("temperature outside saturation range");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.pressure_invalid |->
            o_out_item.pressure_q24_8 == 32'd0)
        else $error("invalid pressure not forced to zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind pressure_temp_compensation ptc_chk u_ptc_chk (.*);

`default_nettype wire
